/* rtl/point_in_polygon_test_top_macros.svh */
// ----------------------------------------------------------------------------
// point_in_polygon_test_top_macros
// Assertion macros for the point-in-polygon test block.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_TOP_MACROS_SVH
`define POINT_IN_POLYGON_TEST_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define PIP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset too.
`define PIP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pip_pkg.sv */
// ----------------------------------------------------------------------------
// pip_pkg
// Types and constants shared by the point-in-polygon test modules.
// ----------------------------------------------------------------------------
`default_nettype none
package pip_pkg;

    localparam int COORD_W          = 24;
    localparam int DIFF_W           = COORD_W + 1;
    localparam int PROD_W           = 2 * DIFF_W;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int PIPE_DEPTH       = 3;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      end_mark;
    } vertex_t;

endpackage
`default_nettype wire

/* rtl/pip_cell.sv */
// ----------------------------------------------------------------------------
// pip_cell
// One vertex slot of the rotating store: loads on append, passes on rotate.
// ----------------------------------------------------------------------------
`default_nettype none
module pip_cell
    import pip_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    load,
    input  wire vertex_t load_data,
    input  wire logic    shift,
    input  wire vertex_t shift_in,
    output vertex_t      data
);

    vertex_t data_reg;

    // hold unless written or rotated
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
        else if (shift)
        begin
            data_reg <= shift_in;
        end
    end

    assign data = data_reg;

endmodule
`default_nettype wire

/* rtl/pip_edge_unit.sv */
// ----------------------------------------------------------------------------
// pip_edge_unit
// Pipelined edge test with crossing parity and hit accumulation.
// ----------------------------------------------------------------------------
`default_nettype none
module pip_edge_unit
    import pip_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      clr,
    input  wire logic                      edge_valid,
    input  wire logic                      edge_last,
    input  wire logic signed [COORD_W-1:0] px,
    input  wire logic signed [COORD_W-1:0] py,
    input  wire vertex_t                   v1,
    input  wire vertex_t                   v2,
    output logic                           hit
);

    typedef struct packed {
        logic valid;
        logic last;
        logic bx;
        logic by;
        logic horiz;
        logic c1;
        logic up1;
        logic c2;
        logic up2;
        logic strict;
        logic dir;
    } edge_flags_t;

    edge_flags_t fa_next, fa_reg, fb_reg;
    logic signed [DIFF_W-1:0] a_reg, b_reg, c_reg, d_reg, na_reg, nd_reg, dx_reg, dy_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, lhs_reg, rhs_reg;
    logic odd_reg, odd_next, hit_reg, hit_next, on_edge, cnt;

    always_comb
    begin
        fa_next.valid  = edge_valid;
        fa_next.last   = edge_last;
        fa_next.bx     = (v1.x <= px && px <= v2.x) || (v2.x <= px && px <= v1.x);
        fa_next.by     = (v1.y <= py && py <= v2.y) || (v2.y <= py && py <= v1.y);
        fa_next.horiz  = (v1.y == v2.y);
        fa_next.c1     = (v1.y == py) && (v1.x <= px);
        fa_next.up1    = (v1.y > v2.y);
        fa_next.c2     = (v2.y == py) && (v2.x <= px);
        fa_next.up2    = (v2.y > v1.y);
        fa_next.strict = (py > v1.y && py < v2.y) || (py > v2.y && py < v1.y);
        fa_next.dir    = (v2.y > v1.y);
    end

    // stage A: differences and flags
    always_ff @(posedge clk)
    begin
        a_reg  <= DIFF_W'(v1.x) - DIFF_W'(px);
        b_reg  <= DIFF_W'(v2.y) - DIFF_W'(py);
        c_reg  <= DIFF_W'(v2.x) - DIFF_W'(px);
        d_reg  <= DIFF_W'(v1.y) - DIFF_W'(py);
        na_reg <= DIFF_W'(px) - DIFF_W'(v1.x);
        nd_reg <= DIFF_W'(py) - DIFF_W'(v1.y);
        dx_reg <= DIFF_W'(v2.x) - DIFF_W'(v1.x);
        dy_reg <= DIFF_W'(v2.y) - DIFF_W'(v1.y);
    end

    // stage B: products
    always_ff @(posedge clk)
    begin
        p1_reg  <= a_reg * b_reg;
        p2_reg  <= c_reg * d_reg;
        lhs_reg <= nd_reg * dx_reg;
        rhs_reg <= na_reg * dy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_reg <= '0;
            fb_reg <= '0;
        end
        else
        begin
            fa_reg <= fa_next;
            fb_reg <= fa_reg;
        end
    end

    always_comb
    begin
        on_edge = (p1_reg == p2_reg) && fb_reg.bx && fb_reg.by;
        if (fb_reg.horiz)
        begin
            cnt = 1'b0;
        end
        else if (fb_reg.c1)
        begin
            cnt = fb_reg.up1;
        end
        else if (fb_reg.c2)
        begin
            cnt = fb_reg.up2;
        end
        else if (!fb_reg.strict)
        begin
            cnt = 1'b0;
        end
        else if (fb_reg.dir)
        begin
            cnt = (lhs_reg <= rhs_reg);
        end
        else
        begin
            cnt = (lhs_reg >= rhs_reg);
        end
    end

    always_comb
    begin
        odd_next = odd_reg;
        hit_next = hit_reg;
        if (fb_reg.valid)
        begin
            if (on_edge)
            begin
                hit_next = 1'b1;
            end
            odd_next = odd_reg ^ cnt;
            if (fb_reg.last)
            begin
                if (odd_next)
                begin
                    hit_next = 1'b1;
                end
                odd_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else if (clr)
        begin
            odd_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            odd_reg <= odd_next;
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule
`default_nettype wire

/* rtl/point_in_polygon_test_top.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// Vertex store as a rotating chain of cells with a pipelined ray-crossing test.
// ----------------------------------------------------------------------------
// Clear, append and unused codes: result one cycle after the transfer.
// Query: rotate through every cell, one edge per step below the vertex count, then
// drain the edge pipeline to the result; the next item is taken once the result has gone.
// The query time is set by the single edge unit walking the cell ring.
// Reset (rst_n, asynchronous, active low) empties the store and the result.
`default_nettype none
`include "point_in_polygon_test_top_macros.svh"
module point_in_polygon_test_top
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                operation,
    input  wire logic signed [COORD_W-1:0] coord_x,
    input  wire logic signed [COORD_W-1:0] coord_y,
    input  wire logic                      polygon_end,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           inside_res,
    output logic                           status
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int DW = $clog2(PIPE_DEPTH);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] step_reg, step_next;
    logic [DW-1:0] drain_reg, drain_next;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    vertex_t first_reg;
    logic    new_poly_reg;
    logic    res_valid_reg, res_valid_next, res_inside_reg, res_inside_next;
    logic    res_status_reg, res_status_next;

    logic    take, rotate, do_append, edge_valid, edge_last, at_tail, hit;
    vertex_t cell_data [MAX_VERTICES];
    vertex_t new_vertex, first_sel, v2_sel;

    assign take       = in_valid && in_ready;
    assign do_append  = take && (op_t'(operation) == OP_APPEND) &&
                        (count_reg < CW'(MAX_VERTICES));
    assign new_vertex = '{x: coord_x, y: coord_y, end_mark: polygon_end};

    // ring of vertex cells; rotate towards cell 0 during a query
    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_cell
        pip_cell u_cell (
            .clk       (clk),
            .load      (do_append && (count_reg == CW'(i))),
            .load_data (new_vertex),
            .shift     (rotate),
            .shift_in  (cell_data[(i + 1) % MAX_VERTICES]),
            .data      (cell_data[i])
        );
    end

    // edge from head vertex to its successor, or back to the polygon's first
    always_comb
    begin
        at_tail    = (CW'(step_reg) + CW'(1)) == count_reg;
        edge_valid = rotate && (CW'(step_reg) < count_reg);
        edge_last  = cell_data[0].end_mark || at_tail;
        first_sel  = new_poly_reg ? cell_data[0] : first_reg;
        v2_sel     = edge_last ? first_sel : cell_data[1];
    end

    pip_edge_unit u_edge (
        .clk        (clk),
        .rst_n      (rst_n),
        .clr        (take),
        .edge_valid (edge_valid),
        .edge_last  (edge_last),
        .px         (px_reg),
        .py         (py_reg),
        .v1         (cell_data[0]),
        .v2         (v2_sel),
        .hit        (hit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && (op_t'(operation) == OP_QUERY))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg == IW'(MAX_VERTICES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == DW'(PIPE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        rotate   = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready = !res_valid_reg;
            ST_RUN:   rotate   = 1'b1;
            ST_DRAIN: in_ready = 1'b0;
            default:  in_ready = 1'b0;
        endcase
    end

    // counters and result
    always_comb
    begin
        count_next      = count_reg;
        step_next       = rotate ? step_reg + IW'(1) : '0;
        drain_next      = (state_reg == ST_DRAIN) ? drain_reg + DW'(1) : '0;
        res_valid_next  = res_valid_reg && !out_ready;
        res_inside_next = res_inside_reg;
        res_status_next = res_status_reg;
        if (take)
        begin
            case (op_t'(operation))
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                OP_APPEND:
                begin
                    if (do_append)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_QUERY:
                begin
                    count_next = count_reg;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
            if (op_t'(operation) != OP_QUERY)
            begin
                res_valid_next  = 1'b1;
                res_inside_next = 1'b0;
                res_status_next = (op_t'(operation) == OP_APPEND) && !do_append;
            end
        end
        if ((state_reg == ST_DRAIN) && (drain_reg == DW'(PIPE_DEPTH - 1)))
        begin
            res_valid_next  = 1'b1;
            res_inside_next = hit;
            res_status_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            drain_reg     <= '0;
            new_poly_reg  <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            drain_reg     <= drain_next;
            res_valid_reg <= res_valid_next;
            // a new polygon opens after each last edge and at every query start
            if (rotate)
            begin
                new_poly_reg <= edge_last;
            end
            else
            begin
                new_poly_reg <= 1'b1;
            end
        end
    end

    // payload: hold query point and first vertex of the current polygon
    always_ff @(posedge clk)
    begin
        res_inside_reg <= res_inside_next;
        res_status_reg <= res_status_next;
        if (take)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rotate)
        begin
            first_reg <= first_sel;
        end
    end

    assign out_valid  = res_valid_reg;
    assign inside_res = res_inside_reg;
    assign status     = res_status_reg;

    `PIP_ASSERT(a_count_range, (count_reg <= CW'(MAX_VERTICES)), "vertex count beyond store depth")
    `PIP_ASSERT(a_no_result_in_run, (rotate |-> !res_valid_reg), "result pending during a query walk")
    `PIP_ASSERT(a_count_frozen, ((state_reg == ST_RUN) |=> $stable(count_reg)), "store changed during a query")
    `PIP_ASSERT(a_flag_only_append, (res_valid_reg && res_status_reg |-> !res_inside_reg), "flagged drop with inside set")

endmodule
`default_nettype wire
